[hdl/tcca_pkg.sv]
package tcca_pkg;

  localparam int unsigned SQRT_STEPS    = 24;
  localparam int unsigned CHI_DIV_STEPS = 32;
  localparam int unsigned FIN_DIV_STEPS = 64;
  localparam int unsigned CNT_W         = 7;

  localparam logic [15:0] MAX_TRK = 16'd255;

  localparam logic [19:0] RES_RESET = 20'd39322;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOASSOC = 2'd1;
  localparam logic [1:0] ST_ERR     = 2'd2;

  localparam logic [1:0] DIV_CHI = 2'd0;
  localparam logic [1:0] DIV_F1  = 2'd1;
  localparam logic [1:0] DIV_F2  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       sqrt_step;
    logic       mul;
    logic       div_load;
    logic [1:0] div_sel;
    logic       div_step;
    logic       sat;
    logic       sqm;
    logic       acc;
    logic       save_qd;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic go_chi;
    logic last;
    logic ok;
    logic out_free;
  } sts_t;

endpackage

[hdl/tcca_div.sv]
module tcca_div import tcca_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [43:0] rem_init,
  input  logic [63:0] num_init,
  input  logic [43:0] divisor,
  output logic [63:0] quotient
);

  logic [43:0] rem_r;
  logic [63:0] num_r;
  logic [43:0] d_r;
  logic [44:0] rem_sh;
  logic        qbit;
  logic [44:0] rem_sub;

  assign rem_sh  = {rem_r, num_r[63]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign qbit    = (rem_sh >= {1'b0, d_r});
  assign quotient = num_r;

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem_init;
      num_r <= num_init;
      d_r   <= divisor;
    end else if (step) begin
      rem_r <= qbit ? rem_sub[43:0] : rem_sh[43:0];
      num_r <= {num_r[62:0], qbit};
    end
  end

endmodule

[hdl/tcca_ctrl.sv]
module tcca_ctrl import tcca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQRT  = 13'b0000000000010,
    S_MUL   = 13'b0000000000100,
    S_DIVLD = 13'b0000000001000,
    S_DIV   = 13'b0000000010000,
    S_SAT   = 13'b0000000100000,
    S_SQM   = 13'b0000001000000,
    S_ACC   = 13'b0000010000000,
    S_CHK   = 13'b0000100000000,
    S_FD1   = 13'b0001000000000,
    S_FD2LD = 13'b0010000000000,
    S_FD2   = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHK;
          if (sts.go_chi) state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_CHI;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CHI_DIV_STEPS - 1)) state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_SQM;
      end
      S_SQM: begin
        cmd.sqm   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.ok) begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DIV_F1;
          state_nxt    = S_FD1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FD1: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FIN_DIV_STEPS - 1)) state_nxt = S_FD2LD;
      end
      S_FD2LD: begin
        cmd.save_qd  = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_F2;
        cnt_nxt      = '0;
        state_nxt    = S_FD2;
      end
      S_FD2: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FIN_DIV_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hdl/tcca_dp.sv]
module tcca_dp import tcca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write,
  input  logic [19:0]        cfg_data,
  input  logic [31:0]        in_had,
  input  logic [31:0]        in_cmp,
  input  logic [31:0]        in_trk,
  input  logic [7:0]         in_ntrk,
  input  logic               in_last,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [47:0] out_chi_total,
  output logic [55:0]        out_chi_squared_total,
  output logic signed [31:0] out_chi_per_dof,
  output logic [47:0]        out_chi_squared_per_dof,
  output logic [41:0]        out_unassociated_energy,
  output logic [31:0]        out_min_associated_energy,
  output logic [17:0]        out_excess_track_count,
  output logic [1:0]         out_status
);

  logic [19:0]        res_r;
  logic signed [47:0] chi_acc_r;
  logic [55:0]        chi2_acc_r;
  logic [41:0]        unassoc_r;
  logic [31:0]        min_r;
  logic [17:0]        excess_r;
  logic [10:0]        count_r;
  logic               err_r;
  logic               last_r;
  logic [47:0]        v_r, root_r, bit_r;
  logic [43:0]        den_r;
  logic               neg_r, ovf_r;
  logic [31:0]        mag_r;
  logic [31:0]        qsat_r;
  logic [46:0]        sq_r;
  logic [47:0]        qd_r;
  logic               out_valid_r;

  logic               ntrk0, bad_in;
  logic [15:0]        ntrk_c;
  logic [42:0]        unassoc_sum;
  logic [18:0]        excess_sum;
  logic [47:0]        rb;
  logic               div_load;
  logic [43:0]        div_rem, div_d;
  logic [63:0]        div_num, quot;
  logic [31:0]        qraw;
  logic signed [48:0] chi_sum;
  logic [56:0]        chi2_sum;
  logic [47:0]        chi_mag;
  logic               ok;
  logic [63:0]        sq_full;

  assign ntrk0  = (in_ntrk == 8'd0);
  assign bad_in = (in_trk == 32'd0) || (res_r == 20'd0);
  assign ntrk_c = ({8'd0, in_ntrk} > MAX_TRK) ? MAX_TRK : {8'd0, in_ntrk};
  assign unassoc_sum = {1'b0, unassoc_r} + {11'd0, in_had};
  assign excess_sum  = {1'b0, excess_r} + {3'd0, ntrk_c - 16'd1};
  assign rb = root_r + bit_r;

  assign ok = !err_r && (count_r != 11'd0);
  assign chi_mag = chi_acc_r[47] ? (48'd0 - chi_acc_r) : chi_acc_r;

  assign sts.go_chi   = !ntrk0 && !bad_in;
  assign sts.last     = last_r;
  assign sts.ok       = ok;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    div_rem = '0;
    div_num = '0;
    div_d   = {33'd0, count_r};
    case (cmd.div_sel)
      DIV_CHI: begin
        div_rem = {12'd0, mag_r};
        div_d   = den_r;
      end
      DIV_F1:  div_num = {16'd0, chi_mag};
      DIV_F2:  div_num = {8'd0, chi2_acc_r};
      default: div_num = '0;
    endcase
  end

  assign div_load = cmd.div_load;

  tcca_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (cmd.div_step),
    .rem_init (div_rem),
    .num_init (div_num),
    .divisor  (div_d),
    .quotient (quot)
  );

  assign qraw    = quot[31:0];
  assign sq_full = {32'd0, qsat_r} * {32'd0, qsat_r};
  assign chi_sum = {chi_acc_r[47], chi_acc_r}
                 + (neg_r ? -$signed({17'd0, qsat_r}) : $signed({17'd0, qsat_r}));
  assign chi2_sum = {1'b0, chi2_acc_r} + {10'd0, sq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r       <= RES_RESET;
      chi_acc_r   <= '0;
      chi2_acc_r  <= '0;
      unassoc_r   <= '0;
      min_r       <= '1;
      excess_r    <= '0;
      count_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) res_r <= cfg_data;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.accept) begin
        if (ntrk0) begin
          unassoc_r <= unassoc_sum[42] ? '1 : unassoc_sum[41:0];
        end else begin
          if (in_had < min_r) min_r <= in_had;
          excess_r <= excess_sum[18] ? '1 : excess_sum[17:0];
          if (bad_in) err_r <= 1'b1;
        end
      end
      if (cmd.acc) begin
        if (chi_sum > $signed({2'b00, {47{1'b1}}}))
          chi_acc_r <= {1'b0, {47{1'b1}}};
        else if (chi_sum < $signed({2'b11, 47'd0}))
          chi_acc_r <= {1'b1, 47'd0};
        else
          chi_acc_r <= chi_sum[47:0];
        chi2_acc_r <= chi2_sum[56] ? '1 : chi2_sum[55:0];
        if (count_r != '1) count_r <= count_r + 11'd1;
      end
      if (cmd.load_out) begin
        chi_acc_r   <= '0;
        chi2_acc_r  <= '0;
        unassoc_r   <= '0;
        min_r       <= '1;
        excess_r    <= '0;
        count_r     <= '0;
        err_r       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_r   <= in_last;
      v_r      <= {in_trk, 16'd0};
      root_r   <= '0;
      bit_r    <= 48'd1 << 46;
      neg_r    <= in_cmp < in_trk;
      mag_r    <= (in_cmp < in_trk) ? (in_trk - in_cmp) : (in_cmp - in_trk);
    end
    if (cmd.sqrt_step) begin
      if (v_r >= rb) begin
        v_r    <= v_r - rb;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mul) den_r <= res_r * root_r[23:0];
    if (cmd.div_load && (cmd.div_sel == DIV_CHI)) ovf_r <= ({12'd0, mag_r} >= den_r);
    if (cmd.sat) begin
      if (neg_r)
        qsat_r <= (ovf_r || qraw > 32'h8000_0000) ? 32'h8000_0000 : qraw;
      else
        qsat_r <= (ovf_r || qraw > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qraw;
    end
    if (cmd.sqm) sq_r <= sq_full[62:16];
    if (cmd.save_qd) qd_r <= quot[47:0];
    if (cmd.load_out) begin
      out_unassociated_energy   <= unassoc_r;
      out_min_associated_energy <= min_r;
      out_excess_track_count    <= excess_r;
      out_status <= err_r ? ST_ERR : (ok ? ST_OK : ST_NOASSOC);
      if (ok) begin
        out_chi_total         <= chi_acc_r;
        out_chi_squared_total <= chi2_acc_r;
        if (chi_acc_r[47])
          out_chi_per_dof <= (qd_r > 48'h8000_0000) ? 32'sh8000_0000
                                                    : 32'd0 - qd_r[31:0];
        else
          out_chi_per_dof <= (qd_r > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : qd_r[31:0];
        out_chi_squared_per_dof <= (quot[63:48] != 16'd0) ? '1 : quot[47:0];
      end else begin
        out_chi_total           <= '0;
        out_chi_squared_total   <= '0;
        out_chi_per_dof         <= '0;
        out_chi_squared_per_dof <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/track_cluster_chi_accumulator_top.sv]
// channel  direction  payload
// in_      input      cluster energies, track sum, track count, last
// out_     output     sums, per-dof averages, status (on last word only)
// cfg_     input      energy resolution, Q4.16
//
// Cluster with tracks: 24 sqrt steps, then multiply, 32 division
// steps, saturate, square, accumulate, check.
// Cluster without tracks or with zero track sum/resolution: straight to check.
// Last word adds two 64-step divisions, skipped when the status is not OK.
// Reset is synchronous, active low; no clearing pass. A result held at the
// output stalls only the next last word; in_ready is low while a word works.
module track_cluster_chi_accumulator_top import tcca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_cluster_hadronic_energy,
  input  logic [31:0]        in_cluster_compare_energy,
  input  logic [31:0]        in_track_energy_sum,
  input  logic [7:0]         in_track_count,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_chi_total,
  output logic [55:0]        out_chi_squared_total,
  output logic signed [31:0] out_chi_per_dof,
  output logic [47:0]        out_chi_squared_per_dof,
  output logic [41:0]        out_unassociated_energy,
  output logic [31:0]        out_min_associated_energy,
  output logic [17:0]        out_excess_track_count,
  output logic [1:0]         out_status
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tcca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcca_dp u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_write                 (cfg_valid),
    .cfg_data                  (cfg_data),
    .in_had                    (in_cluster_hadronic_energy),
    .in_cmp                    (in_cluster_compare_energy),
    .in_trk                    (in_track_energy_sum),
    .in_ntrk                   (in_track_count),
    .in_last                   (in_last),
    .cmd                       (cmd),
    .sts                       (sts),
    .out_ready                 (out_ready),
    .out_valid                 (out_valid),
    .out_chi_total             (out_chi_total),
    .out_chi_squared_total     (out_chi_squared_total),
    .out_chi_per_dof           (out_chi_per_dof),
    .out_chi_squared_per_dof   (out_chi_squared_per_dof),
    .out_unassociated_energy   (out_unassociated_energy),
    .out_min_associated_energy (out_min_associated_energy),
    .out_excess_track_count    (out_excess_track_count),
    .out_status                (out_status)
  );

endmodule

[hdl/tcca_checker.sv]
module tcca_checker import tcca_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] out_chi_total,
  input logic signed [31:0] out_chi_per_dof,
  input logic [31:0]        out_min_associated_energy,
  input logic [1:0]         out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word dropped while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_chi_total == 48'sd0 && out_chi_per_dof == 32'sd0)
    else $error("chi fields not cleared on failure");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOASSOC |-> out_min_associated_energy == 32'hFFFF_FFFF)
    else $error("minimum set with no associated cluster");

endmodule

bind track_cluster_chi_accumulator_top tcca_checker u_tcca_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .out_valid                 (out_valid),
  .out_ready                 (out_ready),
  .out_chi_total             (out_chi_total),
  .out_chi_per_dof           (out_chi_per_dof),
  .out_min_associated_energy (out_min_associated_energy),
  .out_status                (out_status)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tcca_pkg::*;

  typedef struct {
    logic [47:0] chi_tot;
    logic [55:0] chi2_tot;
    logic [31:0] chi_pd;
    logic [47:0] chi2_pd;
    logic [41:0] unassoc;
    logic [31:0] min_e;
    logic [17:0] excess;
    logic [1:0]  status;
  } list_sums_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [19:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [31:0] in_had = '0, in_cmp = '0, in_trk = '0;
  logic [7:0] in_ntrk = '0;
  logic in_last = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [47:0] out_chi_total;
  logic [55:0] out_chi_squared_total;
  logic signed [31:0] out_chi_per_dof;
  logic [47:0] out_chi_squared_per_dof;
  logic [41:0] out_unassociated_energy;
  logic [31:0] out_min_associated_energy;
  logic [17:0] out_excess_track_count;
  logic [1:0] out_status;

  track_cluster_chi_accumulator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cluster_hadronic_energy(in_had), .in_cluster_compare_energy(in_cmp),
    .in_track_energy_sum(in_trk), .in_track_count(in_ntrk), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_chi_total(out_chi_total), .out_chi_squared_total(out_chi_squared_total),
    .out_chi_per_dof(out_chi_per_dof), .out_chi_squared_per_dof(out_chi_squared_per_dof),
    .out_unassociated_energy(out_unassociated_energy),
    .out_min_associated_energy(out_min_associated_energy),
    .out_excess_track_count(out_excess_track_count), .out_status(out_status)
  );

  always #2 clk = ~clk;

  logic [19:0] resolution;
  logic signed [47:0] chi_sum;
  logic [55:0] chi2_sum;
  logic [41:0] unassoc_sum;
  logic [31:0] min_energy;
  logic [17:0] excess_sum;
  logic [10:0] dof_count;
  logic error_flag;
  list_sums_t expected_sums[$];
  int failures = 0;
  int send_idle = 0, recv_idle = 0;
  longint cycles = 0;

  task automatic clear_sums();
    chi_sum = 0; chi2_sum = 0; unassoc_sum = 0; min_energy = '1;
    excess_sum = 0; dof_count = 0; error_flag = 0;
  endtask

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_cluster(logic [31:0] had, logic [31:0] cmp, logic [31:0] trk,
                                 logic [7:0] ntrk, logic last);
    logic neg;
    logic [63:0] mag, s, den, q, sq, qd, q2;
    logic signed [63:0] acc;
    logic [63:0] acc2;
    list_sums_t r;
    if (ntrk == 0) begin
      acc2 = unassoc_sum + had;
      unassoc_sum = (acc2 > 64'h3FFFFFFFFFF) ? '1 : acc2[41:0];
    end else begin
      if (had < min_energy) min_energy = had;
      acc2 = excess_sum + ((ntrk > MAX_TRK) ? MAX_TRK : ntrk) - 1;
      excess_sum = (acc2 > 64'h3FFFF) ? '1 : acc2[17:0];
      if (trk == 0 || resolution == 0) begin
        error_flag = 1;
      end else begin
        neg = cmp < trk;
        mag = neg ? trk - cmp : cmp - trk;
        s = int_sqrt({32'd0, trk} << 16);
        den = resolution * s;
        q = (mag << 32) / den;
        if (neg && q > 64'h80000000) q = 64'h80000000;
        if (!neg && q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
        acc = 64'(chi_sum) + (neg ? -$signed(q) : $signed(q));
        if (acc > 64'sh7FFFFFFFFFFF) acc = 64'sh7FFFFFFFFFFF;
        if (acc < -64'sh800000000000) acc = -64'sh800000000000;
        chi_sum = acc[47:0];
        sq = (q * q) >> 16;
        acc2 = chi2_sum + sq;
        chi2_sum = (acc2 > 64'hFFFFFFFFFFFFFF) ? '1 : acc2[55:0];
        if (dof_count != '1) dof_count++;
      end
    end
    if (!last) return;
    r = '{default: 0};
    r.status = error_flag ? ST_ERR : (dof_count == 0 ? ST_NOASSOC : ST_OK);
    if (r.status == ST_OK) begin
      neg = chi_sum < 0;
      mag = neg ? 64'(-64'(chi_sum)) : 64'(chi_sum);
      qd = mag / dof_count;
      q2 = 64'(chi2_sum) / dof_count;
      if (neg) begin
        if (qd > 64'h80000000) qd = 64'h80000000;
        r.chi_pd = 32'(-qd);
      end else begin
        if (qd > 64'h7FFFFFFF) qd = 64'h7FFFFFFF;
        r.chi_pd = qd[31:0];
      end
      r.chi2_pd = (q2 > 64'hFFFFFFFFFFFF) ? '1 : q2[47:0];
      r.chi_tot = chi_sum;
      r.chi2_tot = chi2_sum;
    end
    r.unassoc = unassoc_sum;
    r.min_e = min_energy;
    r.excess = excess_sum;
    expected_sums.push_back(r);
    clear_sums();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("Some tests failed");
      $finish;
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    list_sums_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, out_status);
        failures++;
      end else begin
        e = expected_sums.pop_front();
        if (e.chi_tot !== out_chi_total || e.chi2_tot !== out_chi_squared_total ||
            e.chi_pd !== out_chi_per_dof || e.chi2_pd !== out_chi_squared_per_dof ||
            e.unassoc !== out_unassociated_energy ||
            e.min_e !== out_min_associated_energy ||
            e.excess !== out_excess_track_count || e.status !== out_status) begin
          $display("%0t mismatch exp %h %h %h %h %h %h %h %h", $time, e.chi_tot,
                   e.chi2_tot, e.chi_pd, e.chi2_pd, e.unassoc, e.min_e, e.excess, e.status);
          $display("%0t          got %h %h %h %h %h %h %h %h", $time, out_chi_total,
                   out_chi_squared_total, out_chi_per_dof, out_chi_squared_per_dof,
                   out_unassociated_energy, out_min_associated_energy,
                   out_excess_track_count, out_status);
          failures++;
        end
      end
    end
  end

  task automatic send_cluster(logic [31:0] had, logic [31:0] cmp, logic [31:0] trk,
                              logic [7:0] ntrk, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_had <= had; in_cmp <= cmp; in_trk <= trk; in_ntrk <= ntrk; in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cluster(had, cmp, trk, ntrk, last);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_resolution(logic [19:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    resolution = v;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_energy();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h00FFFFFF);
      2: return $urandom_range(32'h00010000, 32'h01000000);
      default: return $urandom_range(2) == 0 ? 32'hFFFFFFFF : $urandom_range(3);
    endcase
  endfunction

  task automatic test_directed();
    send_cluster(32'd0, 32'd0, 32'd0, 8'd0, 1);
    send_cluster(32'hFFFFFFFF, 32'd0, 32'd0, 8'd0, 1);
    send_cluster(32'h00050000, 32'h00060000, 32'h00040000, 8'd1, 1);
    send_cluster(32'h00020000, 32'd0, 32'hFFFFFFFF, 8'd255, 0);
    send_cluster(32'h00010000, 32'hFFFFFFFF, 32'd1, 8'd3, 1);
    send_cluster(32'h00010000, 32'd1, 32'd0, 8'd2, 1);
    send_cluster(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd1, 0);
    send_cluster(32'hFFFFFFFF, 32'd0, 32'd0, 8'd0, 0);
    send_cluster(32'hFFFFFFFF, 32'd0, 32'd0, 8'd0, 1);
    send_cluster(32'd0, 32'd0, 32'd1, 8'd1, 0);
    send_cluster(32'd7, 32'hFFFFFFFF, 32'd1, 8'd128, 1);
    send_cluster(32'd7, 32'd0, 32'd1, 8'd200, 0);
    send_cluster(32'd9, 32'd0, 32'h00000100, 8'd1, 1);
  endtask

  task automatic test_resolution_extremes();
    write_resolution(20'd0);
    send_cluster(32'h00030000, 32'h00030000, 32'h00020000, 8'd2, 1);
    send_cluster(32'h00030000, 32'd0, 32'd0, 8'd0, 1);
    write_resolution(20'hFFFFF);
    send_cluster(32'h00030000, 32'hFFFFFFFF, 32'd1, 8'd1, 0);
    send_cluster(32'h00030000, 32'd0, 32'h00020000, 8'd1, 1);
    write_resolution(20'd1);
    send_cluster(32'h00030000, 32'hFFFFFFFF, 32'd1, 8'd1, 0);
    send_cluster(32'h00030000, 32'd0, 32'hFFFFFFFF, 8'd1, 1);
  endtask

  task automatic test_random(int n);
    int len;
    logic [7:0] nt;
    int k;
    for (int i = 0; i < n; i += len) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(5))
          0: nt = 0;
          1: nt = 8'($urandom);
          default: nt = 8'($urandom_range(1, 4));
        endcase
        send_cluster(rand_energy(), rand_energy(),
                     ($urandom_range(19) == 0) ? 32'd0 : rand_energy(), nt, k == len - 1);
      end
    end
  endtask

  initial begin
    resolution = RES_RESET;
    clear_sums();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_resolution_extremes();
    write_resolution(RES_RESET);
    send_idle = 12; recv_idle = 65;
    test_random(340);
    write_resolution(20'h0199A);
    send_idle = 65; recv_idle = 12;
    test_random(340);
    write_resolution(20'($urandom_range(1, 20'hFFFFF)));
    send_idle = 0; recv_idle = 0;
    test_random(340);
    drain();
    if (failures == 0 && expected_sums.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tcca_pkg.sv
hdl/tcca_div.sv
hdl/tcca_ctrl.sv
hdl/tcca_dp.sv
hdl/track_cluster_chi_accumulator_top.sv
hdl/tcca_checker.sv
test/tb_top.sv
